// ===== hdl/sqoe_pkg.sv =====
package sqoe_pkg;

	// Opcodes carried in the func field of a request.
	localparam logic [2:0] FN_PUSH      = 3'd0;
	localparam logic [2:0] FN_PRINT_ALL = 3'd1;
	localparam logic [2:0] FN_PRINT_TOP = 3'd2;
	localparam logic [2:0] FN_POP       = 3'd3;
	localparam logic [2:0] FN_SWAP      = 3'd4;

	// Status codes carried with each result.
	localparam logic [2:0] ST_VALUE      = 3'd0;
	localparam logic [2:0] ST_PRINT_EMPTY = 3'd1;
	localparam logic [2:0] ST_POP_EMPTY  = 3'd2;
	localparam logic [2:0] ST_SWAP_SHORT = 3'd3;
	localparam logic [2:0] ST_PUSH_FULL  = 3'd4;
	localparam logic [2:0] ST_HALTED     = 3'd5;

	// A print-all never gives more results than this.
	localparam int unsigned MAX_RESULTS = 32;
	// Swap needs at least this many entries.
	localparam int unsigned SWAP_MIN = 2;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] printed_value;
		logic [2:0]         status;
		logic               last;
	} rsp_t;

endpackage

// ===== hdl/sqoe_chan_if.sv =====
interface sqoe_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/stack_queue_opcode_engine.sv =====
// Stack/queue opcode engine.
// Requests arrive on req (func, push_value) and results leave on rsp
// (printed_value, status, last); both use valid/ready and move a request at
// an edge where both are high. The cfg channel writes the stack_mode bit
// (1 pushes at the top, 0 at the bottom); it is always ready. The user must
// write it only while the engine is idle; the engine does not enforce this.
// The engine takes one request at a time, and req.ready is high only in the
// idle state. Push, pop and undefined opcodes end in the execute state; errors
// and halted results go on through the emit state, swap through its read and
// write states. Every step uses the one address adder, which drives both the
// read and write address of the entry memory. Print results pass through the
// memory's registered read data and then through the output register.
// Results sit in an output register; while rsp.ready is low the engine waits
// with the finished result and any later one held back, and nothing is lost.
// An error gives one result and sets a sticky halt; after that every request
// gives one halted result. Reset clears the count, top position and halt and
// sets stack mode; entry contents are left as they are.
module stack_queue_opcode_engine
	import sqoe_pkg::*;
#(
	parameter int unsigned DEPTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	sqoe_chan_if.sink   cfg,
	sqoe_chan_if.sink   req,
	sqoe_chan_if.source rsp
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned NLIM = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;
	localparam logic [CNT_W-1:0] NLIM_C = CNT_W'(NLIM);
	localparam logic [CNT_W-1:0] FULL_C = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] BACK_C = CNT_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] SWAP_MIN_C = CNT_W'(SWAP_MIN);
	localparam logic [CNT_W:0]   WRAP_C = (CNT_W + 1)'(DEPTH);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_EXEC   = 8'b0000_0010,
		S_EMIT   = 8'b0000_0100,
		S_PR_RD  = 8'b0000_1000,
		S_PR_OUT = 8'b0001_0000,
		S_SW_RD1 = 8'b0010_0000,
		S_SW_WR0 = 8'b0100_0000,
		S_SW_WR1 = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic               mode_q;
	logic               halted_q;
	logic [PTR_W-1:0]   top_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   idx_q;
	logic               one_q;
	logic [2:0]         func_q;
	logic [31:0]        val_q;
	logic [31:0]        tmp_q;
	logic [2:0]         st_q;
	logic               out_valid_q;
	rsp_t               out_q;

	logic [CNT_W-1:0]   off;
	logic [CNT_W:0]     sum;
	logic [CNT_W:0]     slot;
	logic [PTR_W-1:0]   slot_addr;
	logic [CNT_W-1:0]   n_print;
	logic               out_free;
	logic               pr_last;
	logic               wr_en;
	logic [31:0]        wr_data;
	logic               rd_en;
	logic [31:0]        rd_data;
	logic               is_err;
	logic [2:0]         err_code;

	// Configuration register.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (cfg.valid) begin
			mode_q <= cfg.data;
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || rsp.ready;
	assign n_print   = (count_q > NLIM_C) ? NLIM_C : count_q;
	assign pr_last   = one_q || ((idx_q + CNT_W'(1)) == n_print);

	// Error detection for the latched opcode.
	always_comb begin
		is_err   = 1'b0;
		err_code = ST_VALUE;
		unique case (func_q)
			FN_PUSH: begin
				is_err   = (count_q == FULL_C);
				err_code = ST_PUSH_FULL;
			end
			FN_PRINT_TOP: begin
				is_err   = (count_q == '0);
				err_code = ST_PRINT_EMPTY;
			end
			FN_POP: begin
				is_err   = (count_q == '0);
				err_code = ST_POP_EMPTY;
			end
			FN_SWAP: begin
				is_err   = (count_q < SWAP_MIN_C);
				err_code = ST_SWAP_SHORT;
			end
			default: begin
				is_err   = 1'b0;
				err_code = ST_VALUE;
			end
		endcase
	end

	// Offset chosen for the shared address adder.
	always_comb begin
		off = '0;
		case (state_q)
			S_EXEC: begin
				if (func_q == FN_PUSH) begin
					off = mode_q ? BACK_C : count_q;
				end else if (func_q == FN_POP) begin
					off = CNT_W'(1);
				end
			end
			S_PR_RD:  off = idx_q;
			S_SW_RD1, S_SW_WR1: off = CNT_W'(1);
			default:  off = '0;
		endcase
	end

	// Shared address adder: top position plus offset, wrapped at DEPTH.
	assign sum       = (CNT_W + 1)'(top_q) + {1'b0, off};
	assign slot      = (sum >= WRAP_C) ? (sum - WRAP_C) : sum;
	assign slot_addr = slot[PTR_W-1:0];

	// Memory port controls.
	always_comb begin
		wr_en   = 1'b0;
		wr_data = val_q;
		rd_en   = 1'b0;
		case (state_q)
			S_EXEC: begin
				if (!halted_q && !is_err) begin
					wr_en = (func_q == FN_PUSH);
					rd_en = (func_q == FN_PRINT_ALL && count_q != '0) ||
						(func_q == FN_PRINT_TOP) || (func_q == FN_SWAP);
				end
			end
			S_PR_RD, S_SW_RD1: rd_en = 1'b1;
			S_SW_WR0: begin
				wr_en   = 1'b1;
				wr_data = rd_data;
			end
			S_SW_WR1: begin
				wr_en   = 1'b1;
				wr_data = tmp_q;
			end
			default: begin
				wr_en = 1'b0;
				rd_en = 1'b0;
			end
		endcase
	end

	sqoe_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (PTR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (slot_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (slot_addr),
		.rd_data (rd_data)
	);

	// Sequencer and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			halted_q <= 1'b0;
			top_q    <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			one_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					idx_q <= '0;
					one_q <= (func_q == FN_PRINT_TOP);
					if (halted_q) begin
						state_q <= S_EMIT;
					end else if (is_err) begin
						halted_q <= 1'b1;
						state_q  <= S_EMIT;
					end else begin
						case (func_q)
							FN_PUSH: begin
								if (mode_q) begin
									top_q <= slot_addr;
								end
								count_q <= count_q + CNT_W'(1);
								state_q <= S_IDLE;
							end
							FN_PRINT_ALL: begin
								state_q <= (count_q == '0) ? S_IDLE : S_PR_OUT;
							end
							FN_PRINT_TOP: state_q <= S_PR_OUT;
							FN_POP: begin
								top_q   <= slot_addr;
								count_q <= count_q - CNT_W'(1);
								state_q <= S_IDLE;
							end
							FN_SWAP: state_q <= S_SW_RD1;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_PR_RD: state_q <= S_PR_OUT;
				S_PR_OUT: begin
					if (out_free) begin
						if (pr_last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + CNT_W'(1);
							state_q <= S_PR_RD;
						end
					end
				end
				S_SW_RD1: state_q <= S_SW_WR0;
				S_SW_WR0: state_q <= S_SW_WR1;
				S_SW_WR1: state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// Request payload, error code and swap holding register.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_q <= req.data.func;
			val_q  <= req.data.push_value;
		end
		if (state_q == S_EXEC) begin
			st_q <= halted_q ? ST_HALTED : err_code;
		end
		if (state_q == S_SW_RD1) begin
			tmp_q <= rd_data;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_EMIT || state_q == S_PR_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			out_q.printed_value <= '0;
			out_q.status        <= st_q;
			out_q.last          <= 1'b1;
		end else if (state_q == S_PR_OUT && out_free) begin
			out_q.printed_value <= rd_data;
			out_q.status        <= ST_VALUE;
			out_q.last          <= pr_last;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule

// ===== hdl/sqoe_store.sv =====
module sqoe_store #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned ADDR_W = 5
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [31:0]       wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [31:0]       rd_data
);

	logic [31:0] mem [DEPTH];
	logic [31:0] rd_data_q;

	// One write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// One read port with registered data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sim/stack_queue_opcode_engine_check.sv =====
`timescale 1ns / 1ps

// Follows the engine's store, top position, count and halt from the accepted
// configuration writes and requests, and compares every result with the
// oldest result still owed.
module stack_queue_opcode_engine_check
	import sqoe_pkg::*;
#(
	parameter int unsigned DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        req_valid,
	input  logic        req_ready,
	input  req_t        req_data,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  rsp_t        rsp_data,
	output int unsigned mismatches,
	output int unsigned owed
);

	logic signed [31:0] store [DEPTH];
	int unsigned top_slot;
	int unsigned used;
	logic stopped;
	logic push_on_top;
	rsp_t owed_results[$];
	int unsigned mismatch_total = 0;
	int unsigned owed_total = 0;

	assign mismatches = mismatch_total;
	assign owed = owed_total;

	// Physical slot of the entry that sits pos places below the top.
	function automatic int unsigned slot_of(int unsigned pos);
		return (top_slot + pos) % DEPTH;
	endfunction

	function automatic void owe(logic signed [31:0] value, logic [2:0] status, logic last);
		rsp_t r;
		r.printed_value = value;
		r.status = status;
		r.last = last;
		owed_results.push_back(r);
	endfunction

	// Every error leaves the store alone and halts the engine for good.
	function automatic void halt_with(logic [2:0] status);
		stopped = 1'b1;
		owe('0, status, 1'b1);
	endfunction

	function automatic void execute(req_t r);
		int unsigned n;
		int unsigned a;
		int unsigned b;
		logic signed [31:0] held;
		if (stopped) begin
			owe('0, ST_HALTED, 1'b1);
			return;
		end
		case (r.func)
		FN_PUSH: begin
			if (used >= DEPTH) begin
				halt_with(ST_PUSH_FULL);
			end else begin
				if (push_on_top) begin
					top_slot = (top_slot + DEPTH - 1) % DEPTH;
					store[top_slot] = r.push_value;
				end else begin
					store[slot_of(used)] = r.push_value;
				end
				used++;
			end
		end
		FN_PRINT_ALL: begin
			n = (used > MAX_RESULTS) ? MAX_RESULTS : used;
			for (int unsigned i = 0; i < n; i++) begin
				owe(store[slot_of(i)], ST_VALUE, i + 1 == n);
			end
		end
		FN_PRINT_TOP: begin
			if (used == 0) begin
				halt_with(ST_PRINT_EMPTY);
			end else begin
				owe(store[top_slot], ST_VALUE, 1'b1);
			end
		end
		FN_POP: begin
			if (used == 0) begin
				halt_with(ST_POP_EMPTY);
			end else begin
				top_slot = slot_of(1);
				used--;
			end
		end
		FN_SWAP: begin
			if (used < SWAP_MIN) begin
				halt_with(ST_SWAP_SHORT);
			end else begin
				a = slot_of(0);
				b = slot_of(1);
				held = store[a];
				store[a] = store[b];
				store[b] = held;
			end
		end
		default: begin
			// Undefined opcodes are dropped without a result.
		end
		endcase
	endfunction

	// Returns the number of wrong fields, or one for a result nobody owes.
	function automatic int unsigned compare_result(rsp_t got);
		rsp_t want;
		int unsigned faults = 0;
		if (owed_results.size() == 0) begin
			$display("%0t: unexpected result, value %0d status %0d last %0d",
				$time, got.printed_value, got.status, got.last);
			return 1;
		end
		want = owed_results.pop_front();
		if (got.printed_value !== want.printed_value) begin
			$display("%0t: printed_value expected %0d, got %0d",
				$time, want.printed_value, got.printed_value);
			faults++;
		end
		if (got.status !== want.status) begin
			$display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
			faults++;
		end
		if (got.last !== want.last) begin
			$display("%0t: last expected %0d, got %0d", $time, want.last, got.last);
			faults++;
		end
		return faults;
	endfunction

	// Results are checked before new requests are taken in; both keep order.
	always @(posedge clk or negedge arst_n) begin : track
		int unsigned step_faults;
		if (!arst_n) begin
			top_slot = 0;
			used = 0;
			stopped = 1'b0;
			push_on_top = 1'b1;
			owed_results.delete();
			owed_total <= 0;
		end else begin
			step_faults = 0;
			if (rsp_valid && rsp_ready) begin
				step_faults = compare_result(rsp_data);
			end
			if (cfg_valid && cfg_ready) begin
				push_on_top = cfg_data;
			end
			if (req_valid && req_ready) begin
				execute(req_data);
			end
			mismatch_total <= mismatch_total + step_faults;
			owed_total <= owed_results.size();
		end
	end

endmodule

// ===== sim/stack_queue_opcode_engine_test.sv =====
`timescale 1ns / 1ps

module stack_queue_opcode_engine_test;
	import sqoe_pkg::*;

	localparam int unsigned DEPTH = 32;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned PHASE_ITEMS = 85;

	// Opcodes the engine does not define.
	localparam logic [2:0] FN_UNDEF_FIRST = 3'd5;
	localparam logic [2:0] FN_UNDEF_MID = 3'd6;
	localparam logic [2:0] FN_UNDEF_LAST = 3'd7;

	logic clk;
	logic arst_n;
	int unsigned mismatches;
	int unsigned owed;
	// Entries held by the engine, counted from the accepted requests.
	int unsigned stored = 0;
	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;
	bit hold_rsp = 1'b0;

	sqoe_chan_if #(.payload_t(logic)) cfg_ch ();
	sqoe_chan_if #(.payload_t(req_t)) req_ch ();
	sqoe_chan_if #(.payload_t(rsp_t)) rsp_ch ();

	stack_queue_opcode_engine #(
		.DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	stack_queue_opcode_engine_check #(
		.DEPTH(DEPTH)
	) result_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_ch.valid),
		.cfg_ready(cfg_ch.ready),
		.cfg_data(cfg_ch.data),
		.req_valid(req_ch.valid),
		.req_ready(req_ch.ready),
		.req_data(req_ch.data),
		.rsp_valid(rsp_ch.valid),
		.rsp_ready(rsp_ch.ready),
		.rsp_data(rsp_ch.data),
		.mismatches(mismatches),
		.owed(owed)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Hard stop in case the engine hangs.
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Result side: short random stalls, and one long hold when asked for.
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	function automatic logic signed [31:0] random_value();
		case ($urandom_range(0, 7))
		0: return 32'sh7FFF_FFFF;
		1: return 32'sh8000_0000;
		2: return '0;
		3: return -32'sd1;
		default: return $signed($urandom);
		endcase
	endfunction

	// Offers one request, after a random gap when gaps are enabled, and
	// returns once it is accepted. Valid stays high for the next request.
	task automatic issue(input logic [2:0] op, input logic signed [31:0] value);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= '{func: op, push_value: value};
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (op == FN_PUSH && stored < DEPTH) begin
			stored++;
		end else if (op == FN_POP && stored > 0) begin
			stored--;
		end
	endtask

	// Stops offering requests and waits until the engine has gone idle.
	task automatic drain_engine();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (owed != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(input logic mode);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= mode;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic fill_store();
		while (stored < DEPTH) issue(FN_PUSH, random_value());
	endtask

	task automatic empty_to(input int unsigned level);
		while (stored > level) issue(FN_POP, random_value());
	endtask

	// Random opcodes with random values. Requests that would raise an error
	// are turned into legal ones, since a single error halts the engine.
	task automatic random_mix(input int unsigned count, input int unsigned push_pct);
		int unsigned done;
		int unsigned roll;
		logic [2:0] op;
		done = 0;
		while (done < count) begin
			roll = $urandom_range(0, 99);
			if (roll < push_pct) begin
				op = FN_PUSH;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 35) begin
					op = FN_POP;
				end else if (roll < 60) begin
					op = FN_SWAP;
				end else if (roll < 80) begin
					op = FN_PRINT_TOP;
				end else if (roll < 95) begin
					op = FN_PRINT_ALL;
				end else begin
					op = 3'($urandom_range(FN_UNDEF_FIRST, FN_UNDEF_LAST));
				end
			end
			if (op == FN_PUSH && stored >= DEPTH) begin
				op = FN_POP;
			end else if ((op == FN_POP || op == FN_PRINT_TOP) && stored == 0) begin
				op = FN_PUSH;
			end else if (op == FN_SWAP && stored < SWAP_MIN) begin
				op = FN_PUSH;
			end
			issue(op, random_value());
			if (op <= FN_SWAP) begin
				done++;
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part in stack mode: edge values, every opcode, the
		// undefined opcodes, and a print-all on an empty store.
		set_mode(1'b1);
		issue(FN_PRINT_ALL, '0);
		issue(FN_PUSH, 32'sh7FFF_FFFF);
		issue(FN_PUSH, 32'sh8000_0000);
		issue(FN_PUSH, '0);
		issue(FN_PUSH, -32'sd1);
		issue(FN_PRINT_TOP, '0);
		issue(FN_PRINT_ALL, '0);
		issue(FN_SWAP, '0);
		issue(FN_PRINT_ALL, '0);
		issue(FN_POP, '0);
		issue(FN_PRINT_TOP, '0);
		issue(FN_UNDEF_FIRST, 32'sh1234_5678);
		issue(FN_UNDEF_MID, '0);
		issue(FN_UNDEF_LAST, -32'sd1);
		issue(FN_PUSH, 32'sh5555_5555);
		issue(FN_PUSH, 32'shAAAA_AAAA);
		issue(FN_PRINT_ALL, '0);

		// The same opcodes with pushes going to the bottom.
		drain_engine();
		set_mode(1'b0);
		issue(FN_PUSH, 32'sd1);
		issue(FN_PUSH, -32'sd2);
		issue(FN_PRINT_ALL, '0);
		issue(FN_SWAP, '0);
		issue(FN_PRINT_TOP, '0);
		issue(FN_POP, '0);
		issue(FN_PRINT_ALL, '0);

		// Random traffic in queue mode with idling on both sides.
		gap_pct = 25;
		stall_pct = 25;
		random_mix(PHASE_ITEMS, 45);

		// Stack mode: fill the store without idling, then hold results back
		// while print requests keep coming so the engine backs up.
		drain_engine();
		set_mode(1'b1);
		gap_pct = 0;
		stall_pct = 0;
		fill_store();
		hold_rsp = 1'b1;
		issue(FN_PRINT_ALL, '0);
		issue(FN_PRINT_TOP, '0);
		issue(FN_PRINT_ALL, '0);
		gap_pct = 15;
		stall_pct = 35;
		random_mix(PHASE_ITEMS, 35);

		// Queue mode again, ending on a full store.
		drain_engine();
		set_mode(1'b0);
		gap_pct = 40;
		stall_pct = 10;
		random_mix(PHASE_ITEMS, 60);
		fill_store();
		issue(FN_PRINT_ALL, '0);

		drain_engine();
		set_mode(1'b1);
		gap_pct = 10;
		stall_pct = 50;
		random_mix(PHASE_ITEMS, 50);

		// Final part without idling: run into one of the errors, then check
		// that the halt answers every opcode.
		drain_engine();
		gap_pct = 0;
		stall_pct = 0;
		case (3'($urandom_range(ST_PRINT_EMPTY, ST_PUSH_FULL)))
		ST_PRINT_EMPTY: begin
			empty_to(0);
			issue(FN_PRINT_TOP, '0);
		end
		ST_POP_EMPTY: begin
			empty_to(0);
			issue(FN_POP, '0);
		end
		ST_SWAP_SHORT: begin
			empty_to(1);
			if (stored == 0) begin
				issue(FN_PUSH, random_value());
			end
			issue(FN_SWAP, '0);
		end
		default: begin
			fill_store();
			issue(FN_PUSH, random_value());
		end
		endcase
		issue(FN_PUSH, random_value());
		issue(FN_PRINT_ALL, '0);
		issue(FN_PRINT_TOP, '0);
		issue(FN_POP, '0);
		issue(FN_SWAP, '0);
		issue(FN_UNDEF_LAST, '0);

		drain_engine();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && owed == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
